// ----- rtl/edd_pkg.sv -----
// Shared types and the saturating pixel add for the error diffusion dither.
package edd_pkg;

  // Scaled error parts: right, down, down-left and down-right.
  typedef struct packed {
    logic signed [7:0] e7;
    logic signed [7:0] e5;
    logic signed [7:0] e3;
    logic signed [7:0] e1;
  } edd_err_t;

  // Control broadcast to every cell of the pixel line.
  typedef struct packed {
    logic       shift;
    logic       diffuse;
    logic       load;
    logic [7:0] load_val;
    edd_err_t   err;
  } edd_ctl_t;

  localparam logic [7:0] PIX_MAX = 8'd255;

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic signed [7:0] e);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(e);
    if (s > 10'sd255) begin
      sat_add = PIX_MAX;
    end else if (s < 10'sd0) begin
      sat_add = 8'd0;
    end else begin
      sat_add = s[7:0];
    end
  endfunction

endpackage

// ----- rtl/edd_err.sv -----
// Quantization error of the oldest pixel, scaled by 7, 5, 3 and 1 over 16.
module edd_err (
  input  logic [7:0]        pix,
  output edd_pkg::edd_err_t err
);

  logic signed [8:0]  e9;
  logic signed [11:0] e12;
  logic signed [11:0] p7;
  logic signed [11:0] p5;
  logic signed [11:0] p3;

  // Truncate toward zero: bias negative values before the shift.
  function automatic logic signed [7:0] div16(input logic signed [11:0] p);
    logic signed [11:0] q;
    if (p < 12'sd0) begin
      q = (p + 12'sd15) >>> 4;
    end else begin
      q = p >>> 4;
    end
    div16 = q[7:0];
  endfunction

  always_comb begin
    if (pix[7]) begin
      e9 = $signed({1'b0, pix}) - 9'sd255;
    end else begin
      e9 = $signed({1'b0, pix});
    end
    e12 = 12'(e9);
    p7  = (e12 <<< 3) - e12;
    p5  = (e12 <<< 2) + e12;
    p3  = (e12 <<< 1) + e12;
    err.e7 = div16(p7);
    err.e5 = div16(p5);
    err.e3 = div16(p3);
    err.e1 = div16(e12);
  end

endmodule

// ----- rtl/edd_cell.sv -----
// One waiting pixel of the line: takes its share of the error and shifts toward the head.
module edd_cell #(
  parameter int IDX = 0,
  parameter int IW  = 10
) (
  input  logic              clk,
  input  edd_pkg::edd_ctl_t ctl,
  input  logic [IW-1:0]     w_idx,
  input  logic [IW-1:0]     wm1_idx,
  input  logic [IW-1:0]     tail_idx,
  input  logic [7:0]        from_next,
  output logic [7:0]        value,
  output logic [7:0]        mod_value
);

  logic [7:0]        pix_r;
  logic [7:0]        pix_nxt;
  logic signed [7:0] add;

  // Pick this cell's part of the error by its place relative to the head.
  always_comb begin
    if (!ctl.diffuse) begin
      add = 8'sd0;
    end else if (IDX == 1) begin
      add = ctl.err.e7;
    end else if (w_idx == IW'(IDX)) begin
      add = ctl.err.e5;
    end else if (wm1_idx == IW'(IDX)) begin
      add = ctl.err.e3;
    end else begin
      add = 8'sd0;
    end
  end

  assign mod_value = edd_pkg::sat_add(pix_r, add);
  assign value     = pix_r;

  always_comb begin
    if (ctl.load && (tail_idx == IW'(IDX))) begin
      pix_nxt = ctl.load_val;
    end else if (ctl.shift) begin
      pix_nxt = from_next;
    end else begin
      pix_nxt = pix_r;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule

// ----- rtl/error_diffusion_dither_top.sv -----
// Top level of the error diffusion dither: config registers, stream control, pixel line.
//
//  channel  dir  transfer                       payload
//  in_      in   in_tvalid & in_tready          tdata gray_value, tuser drain
//  out_     out  out_tvalid & out_tready        tdata dot, tlast row_last, tuser frame_last
//  cfg_     in   psel & penable & pwrite        frame_width at 0x0, frame_height at 0x4
//
// One item per clock while in_tready is high; a dot leaves on out_ from the output register,
// and each dot lags its pixel by width+1 items (the fill level of the cell line).
// The error path runs combinationally from the head cell through the scaler into the cells.
// Reset is synchronous; the pixel line holds no valid data until filled.
// A skid register holds one dot while out_tready is low; in_tready drops while it is full.
module error_diffusion_dither_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] gray_value
  input  logic [0:0]  in_tuser,    // [0] drain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] dot, [7:1] zero
  output logic        out_tlast,   // row_last
  output logic [0:0]  out_tuser,   // [0] frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N  = MAX_WIDTH + 1;
  localparam int IW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(MAX_WIDTH + 2);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic dot;
    logic row_last;
    logic frame_last;
  } res_t;

  logic [9:0]  frame_width_r;
  logic [10:0] frame_height_r;
  logic        cfg_wr;

  logic [IW-1:0] w_eff;
  logic [IW-1:0] wm1;
  logic [HW-1:0] h_eff;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [LW-1:0] lag_r, lag_nxt;

  logic accept, drain, flushing, fill, steady, emit, diffuse;
  logic in_col_last, in_row_last, out_col_last, out_row_last;
  logic [7:0]    gray_mod;
  logic [IW-1:0] tail_idx;

  edd_pkg::edd_err_t err;
  edd_pkg::edd_ctl_t ctl;

  logic [7:0] val_w  [N];
  logic [7:0] mod_w  [N];
  logic [7:0] from_w [N];

  res_t res;
  res_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 10'd384;
      frame_height_r <= 11'd288;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[9:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = {22'd0, frame_width_r};
      REG_FRAME_HEIGHT: cfg_prdata = {21'd0, frame_height_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (frame_width_r == 10'd0) begin
      w_eff = IW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = IW'(MAX_WIDTH);
    end else begin
      w_eff = IW'(frame_width_r);
    end
    if (frame_height_r == 11'd0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  assign wm1 = w_eff - IW'(1);

  // Item classification
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid & in_tready;
  assign drain     = in_tuser[0];

  assign in_col_last  = (IW'(in_col_r) + IW'(1)) >= w_eff;
  assign in_row_last  = (HW'(in_row_r) + HW'(1)) >= h_eff;
  assign out_col_last = (IW'(out_col_r) + IW'(1)) >= w_eff;
  assign out_row_last = (HW'(out_row_r) + HW'(1)) >= h_eff;

  assign flushing = (in_row_r == '0) && (in_col_r == '0) && (lag_r != '0);
  assign fill     = !flushing && !drain && (lag_r < (LW'(w_eff) + LW'(1)));
  assign steady   = !flushing && !drain && !fill;
  assign emit     = flushing || steady;
  // No diffusion from the last row or from the first or last column
  assign diffuse  = steady && !out_row_last && (out_col_r != '0) && !out_col_last;

  assign gray_mod = diffuse ? edd_pkg::sat_add(in_tdata, err.e1) : in_tdata;
  assign tail_idx = fill ? IW'(lag_r) : IW'(lag_r - LW'(1));

  assign ctl.shift    = accept && emit;
  assign ctl.diffuse  = accept && diffuse;
  assign ctl.load     = accept && (fill || steady);
  assign ctl.load_val = fill ? in_tdata : gray_mod;
  assign ctl.err      = err;

  edd_err u_err (
    .pix (val_w[0]),
    .err (err)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_end
      assign from_w[i] = val_w[i];
    end else begin : g_mid
      assign from_w[i] = mod_w[i+1];
    end
    edd_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .w_idx     (w_eff),
      .wm1_idx   (wm1),
      .tail_idx  (tail_idx),
      .from_next (from_w[i]),
      .value     (val_w[i]),
      .mod_value (mod_w[i])
    );
  end

  // Position counters and fill level
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lag_nxt     = lag_r;
    if (accept && (fill || steady)) begin
      if (in_col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_last ? '0 : in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (accept && emit) begin
      if (out_col_last) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_last ? '0 : out_row_r + RW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (accept && fill) begin
      lag_nxt = lag_r + LW'(1);
    end else if (accept && flushing) begin
      lag_nxt = lag_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lag_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_r     <= lag_nxt;
    end
  end

  // Output register with skid stage
  assign res.dot        = val_w[0][7];
  assign res.row_last   = out_col_last;
  assign res.frame_last = out_col_last && out_row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_tready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_tready) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (accept && emit) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = {7'd0, main_r.dot};
  assign out_tlast  = main_r.row_last;
  assign out_tuser  = main_r.frame_last;

endmodule

// ----- rtl/edd_checker.sv -----
// Port-level checks for the error diffusion dither, bound to the top level.
module edd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic       out_tlast,
  input logic [0:0] out_tuser,
  input logic       cfg_pready
);

  // A dot held back by the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  // End of frame is also end of row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame_last without row_last");

  // Input stalls only while both output stages hold a dot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with empty output");

  // Reset empties both output stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind error_diffusion_dither_top edd_checker u_edd_checker (.*);
